>>> rtl/ccr_pkg.sv
// ----------------------------------------------------------------------------
// ccr_pkg
// Shared types and constants of the character class refinement block.
// ----------------------------------------------------------------------------
`default_nettype none

package ccr_pkg;

    localparam logic [8:0] ALPHABET    = 9'd256;
    localparam logic [9:0] CHR_LAST    = {1'b0, ALPHABET} - 10'd1;
    localparam logic [8:0] MAX_CLASS   = 9'd511;
    localparam logic [9:0] CLASS_LIMIT = 10'd512;

    // one command per cycle from controller to datapath
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_CLR,
        CMD_A_RDC,
        CMD_A_RDI,
        CMD_A_WR,
        CMD_C_RD,
        CMD_C_WR,
        CMD_D_RDC,
        CMD_D_RDI,
        CMD_D_WR,
        CMD_S_RDC,
        CMD_S_RDK,
        CMD_S_WR,
        CMD_O_CAP
    } t_cmd;

    typedef struct packed {
        logic cls_last;   // class counter at top-1
        logic chr_last;   // char counter at last symbol
        logic cnt_zero;
        logic lookup;
        logic single;
        logic out_taken;
    } t_stat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLR,
        ST_A_RDC,
        ST_A_RDI,
        ST_A_WR,
        ST_C_RD,
        ST_C_WR,
        ST_D_RDC,
        ST_D_RDI,
        ST_D_WR,
        ST_S_RDC,
        ST_S_RDK,
        ST_S_WR,
        ST_O_RDC,
        ST_O_CAP,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

>>> rtl/ccr_ctrl.sv
// ----------------------------------------------------------------------------
// ccr_ctrl
// Sequencer: walks the refine phases and issues one command per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ccr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    input  wire ccr_pkg::t_stat i_stat,
    output      logic          o_s_tready,
    output      ccr_pkg::t_cmd o_cmd
);
    import ccr_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = CMD_NONE;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd = CMD_LOAD;
                    n_state = ST_CLR;
                end
            end
            ST_CLR: begin
                // item fields are latched now
                if (i_stat.lookup) begin
                    n_state = ST_O_RDC;
                end else if (i_stat.single) begin
                    n_state = ST_S_RDC;
                end else begin
                    o_cmd = CMD_CLR;
                    if (i_stat.cls_last) n_state = ST_A_RDC;
                end
            end
            ST_A_RDC: begin o_cmd = CMD_A_RDC; n_state = ST_A_RDI; end
            ST_A_RDI: begin o_cmd = CMD_A_RDI; n_state = ST_A_WR; end
            ST_A_WR: begin
                o_cmd = CMD_A_WR;
                n_state = i_stat.chr_last ? ST_C_RD : ST_A_RDC;
            end
            ST_C_RD: begin o_cmd = CMD_C_RD; n_state = ST_C_WR; end
            ST_C_WR: begin
                o_cmd = CMD_C_WR;
                n_state = i_stat.cnt_zero ? ST_D_RDC : ST_C_RD;
            end
            ST_D_RDC: begin o_cmd = CMD_D_RDC; n_state = ST_D_RDI; end
            ST_D_RDI: begin o_cmd = CMD_D_RDI; n_state = ST_D_WR; end
            ST_D_WR: begin
                o_cmd = CMD_D_WR;
                n_state = i_stat.chr_last ? ST_O_RDC : ST_D_RDC;
            end
            ST_S_RDC: begin o_cmd = CMD_S_RDC; n_state = ST_S_RDK; end
            ST_S_RDK: begin o_cmd = CMD_S_RDK; n_state = ST_S_WR; end
            ST_S_WR:  begin o_cmd = CMD_S_WR;  n_state = ST_O_RDC; end
            ST_O_RDC: begin o_cmd = CMD_S_RDC; n_state = ST_O_CAP; end
            ST_O_CAP: begin o_cmd = CMD_O_CAP; n_state = ST_OUT; end
            ST_OUT: begin
                if (i_stat.out_taken) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/ccr_dpath.sv
// ----------------------------------------------------------------------------
// ccr_dpath
// Class tables, counters and result register of the refinement block.
// ----------------------------------------------------------------------------
`default_nettype none

module ccr_dpath (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ccr_pkg::t_cmd  i_cmd,
    input  wire logic [1:0]     i_s_tuser,
    input  wire logic [263:0]   i_s_tdata,
    input  wire logic           i_m_tready,
    output      ccr_pkg::t_stat o_stat,
    output      logic           o_m_tvalid,
    output      logic [23:0]    o_m_tdata
);
    import ccr_pkg::*;

    // item
    logic         r_op, r_single;
    logic [7:0]   r_ch;
    logic [255:0] r_set;
    logic [9:0]   r_top, r_next, r_cnt;

    // char -> class table, cleared by valid bits
    logic [8:0]   cc_mem [256];
    logic [255:0] r_cc_valid;
    logic [8:0]   r_cc_q;
    logic         r_cc_v;
    // per class scratch: {inside, outside, split, new id}
    logic [11:0]  ci_mem [512];
    logic [11:0]  r_ci_q;
    // class kind, 1 = single; class 0 is never written and reads set-type
    logic         kind_mem [512];
    logic         r_kind_q, r_kind_z;

    logic [8:0]   r_cls;
    logic         r_out_vld;
    logic [8:0]   r_out_id;
    logic [9:0]   r_out_tot;

    logic [8:0]   w_cls, w_take, w_cc_addr9;
    logic [7:0]   w_cc_addr;
    logic         w_bit, w_ch_ok, w_kind;
    logic [9:0]   w_next_inc;

    assign w_cls      = r_cc_v ? r_cc_q : 9'd0;
    assign w_bit      = r_set[r_cnt[7:0]];
    assign w_ch_ok    = {1'b0, r_ch} < ALPHABET;
    assign w_take     = (r_next > {1'b0, MAX_CLASS}) ? MAX_CLASS : r_next[8:0];
    assign w_next_inc = (r_next < CLASS_LIMIT) ? r_next + 10'd1 : r_next;
    assign w_kind     = r_kind_z ? 1'b0 : r_kind_q;
    assign w_cc_addr  = (i_cmd == CMD_S_RDC) ? r_ch : r_cnt[7:0];
    assign w_cc_addr9 = (i_cmd == CMD_C_RD) ? r_cnt[8:0] : w_cls;

    always_comb begin
        o_stat.cls_last  = (r_cnt == r_top - 10'd1);
        o_stat.chr_last  = (r_cnt == CHR_LAST);
        o_stat.cnt_zero  = (r_cnt == 10'd0);
        o_stat.lookup    = r_op;
        o_stat.single    = r_single;
        o_stat.out_taken = r_out_vld & i_m_tready;
    end

    // table reads
    always_ff @(posedge i_clk) begin
        r_cc_q   <= cc_mem[w_cc_addr];
        r_cc_v   <= r_cc_valid[w_cc_addr];
        r_ci_q   <= ci_mem[w_cc_addr9];
        r_kind_q <= kind_mem[w_cc_addr9];
        r_kind_z <= (w_cc_addr9 == 9'd0);
        if (i_cmd == CMD_A_RDI || i_cmd == CMD_D_RDI || i_cmd == CMD_S_RDK)
            r_cls <= w_cls;
    end

    // table writes
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_CLR:  ci_mem[r_cnt[8:0]] <= 12'd0;
            CMD_A_WR: ci_mem[r_cls] <= {r_ci_q[11] | w_bit, r_ci_q[10] | ~w_bit,
                                        r_ci_q[9:0]};
            CMD_C_WR: begin
                if (r_ci_q[11] && r_ci_q[10] && !w_kind) begin
                    ci_mem[r_cnt[8:0]] <= {r_ci_q[11:10], 1'b1, w_take};
                    kind_mem[w_take]   <= 1'b0;
                end
            end
            CMD_D_WR: begin
                if (r_ci_q[9] && w_bit) cc_mem[r_cnt[7:0]] <= r_ci_q[8:0];
            end
            CMD_S_WR: begin
                if (w_ch_ok && !w_kind) begin
                    kind_mem[w_take] <= 1'b1;
                    cc_mem[r_ch]     <= w_take;
                end
            end
            default: ;
        endcase
    end

    // item latch and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_LOAD) begin
            r_op     <= i_s_tuser[0];
            r_single <= i_s_tuser[1];
            r_ch     <= i_s_tdata[7:0];
            r_set    <= i_s_tdata[263:8];
        end
        if (i_cmd == CMD_O_CAP) begin
            r_out_id  <= w_ch_ok ? w_cls : 9'd0;
            r_out_tot <= r_next;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next     <= 10'd1;
            r_top      <= 10'd1;
            r_cnt      <= 10'd0;
            r_cc_valid <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            case (i_cmd)
                CMD_LOAD: begin
                    r_top <= r_next;
                    r_cnt <= 10'd0;
                end
                CMD_CLR:  r_cnt <= o_stat.cls_last ? 10'd0 : r_cnt + 10'd1;
                CMD_A_WR: r_cnt <= o_stat.chr_last ? r_top - 10'd1 : r_cnt + 10'd1;
                CMD_C_WR: begin
                    if (r_ci_q[11] && r_ci_q[10] && !w_kind) r_next <= w_next_inc;
                    if (!o_stat.cnt_zero) r_cnt <= r_cnt - 10'd1;
                end
                CMD_D_WR: begin
                    if (r_ci_q[9] && w_bit) r_cc_valid[r_cnt[7:0]] <= 1'b1;
                    r_cnt <= o_stat.chr_last ? 10'd0 : r_cnt + 10'd1;
                end
                CMD_S_WR: begin
                    if (w_ch_ok && !w_kind) begin
                        r_next           <= w_next_inc;
                        r_cc_valid[r_ch] <= 1'b1;
                    end
                end
                default: ;
            endcase
            if (i_cmd == CMD_O_CAP) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {5'd0, r_out_tot, r_out_id};

endmodule

`default_nettype wire

>>> rtl/char_class_refine_core.sv
// ----------------------------------------------------------------------------
// char_class_refine_core
// Partition refinement of a 256-symbol alphabet into equivalence classes.
// ----------------------------------------------------------------------------
// Keeps every character's class number; after reset all are in class 0.
// One transaction in gives one transaction out, and each result waits until
// it is taken. A set refine, where T is the class count at arrival, runs a
// clear sweep over T scratch entries, a read-modify-write per char to mark
// which classes the set cuts, a step per class (highest first) handing out
// new numbers, and a second pass per char moving members. The single-port
// class tables pace each of these steps. One item at a time: tready is high
// only while idle.
`default_nettype none

module char_class_refine_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output      logic         o_s_tready,
    input  wire logic [263:0] i_s_tdata,  // char_value, set_w0, set_w1, set_w2, set_w3
    input  wire logic [1:0]   i_s_tuser,  // op, is_single
    output      logic         o_m_tvalid,
    input  wire logic         i_m_tready,
    output      logic [23:0]  o_m_tdata   // class_id, class_total, zero fill
);
    import ccr_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    ccr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_stat     (w_stat),
        .o_s_tready (o_s_tready),
        .o_cmd      (w_cmd)
    );

    ccr_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_s_tuser  (i_s_tuser),
        .i_s_tdata  (i_s_tdata),
        .i_m_tready (i_m_tready),
        .o_stat     (w_stat),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

    // one item in flight: never ready while a result waits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("ready while result pending");

    // accepted transaction closes the input side
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("ready right after accept");

    // class number always below count handed out
    a_id_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[18:9] != 10'd0 &&
                        {1'b0, o_m_tdata[8:0]} < o_m_tdata[18:9]))
        else $error("class id out of range");

endmodule

`default_nettype wire
